@@ hw/rtl/ssi_pkg.sv @@
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and constants of the simpson stream integrator
// widths, register indexes, reset values and the structs passed between units
// ----------------------------------------------------------------------------
package ssi_pkg;

    // fixed field and state widths
    localparam int COUNT_WIDTH  = 16;
    localparam int SAMPLE_WIDTH = 32;
    localparam int ACC_WIDTH    = 52;
    localparam int OUT_WIDTH    = 48;
    localparam int NP_WIDTH     = 16;
    localparam int STEP_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;

    // configuration port
    localparam int CFG_WIDTH      = 32;
    localparam int CFG_ADDR_WIDTH = 1;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        CFG_NUM_POINTS = 1'b0,
        CFG_STEP_SIZE  = 1'b1
    } t_cfg_addr;

    localparam logic [NP_WIDTH-1:0]   NUM_POINTS_RESET = NP_WIDTH'(3);
    localparam logic [STEP_WIDTH-1:0] STEP_SIZE_RESET  = STEP_WIDTH'(1) << FRAC_BITS;
    localparam int                    MIN_POINTS       = 3;
    localparam int                    TAIL_POINTS      = 4;

    // index compare width: holds either operand plus one
    localparam int CMP_WIDTH = ((COUNT_WIDTH > NP_WIDTH) ? COUNT_WIDTH : NP_WIDTH) + 1;

    // final scaling h*(8s+9t) / (3 * 2^(FRAC_BITS+3))
    localparam int SCALE_SHIFT  = FRAC_BITS + 3;
    localparam int X_WIDTH      = ACC_WIDTH + 5;
    localparam int MAG_WIDTH    = ACC_WIDTH + 4;
    localparam int MAG_LO_WIDTH = MAG_WIDTH / 2;
    localparam int MAG_HI_WIDTH = MAG_WIDTH - MAG_LO_WIDTH;
    localparam int PLO_WIDTH    = MAG_LO_WIDTH + STEP_WIDTH;
    localparam int PHI_WIDTH    = MAG_HI_WIDTH + STEP_WIDTH;
    localparam int PROD_WIDTH   = MAG_WIDTH + STEP_WIDTH + 1;
    localparam int V_WIDTH      = PROD_WIDTH - SCALE_SHIFT;

    localparam logic [PROD_WIDTH-1:0] ROUND_ADD = PROD_WIDTH'(3) << (SCALE_SHIFT - 1);
    localparam logic [V_WIDTH-1:0]    SAT_POS   = V_WIDTH'(3) << (OUT_WIDTH - 1);
    localparam logic [V_WIDTH-1:0]    SAT_NEG   = SAT_POS + V_WIDTH'(3);

    localparam logic [OUT_WIDTH-1:0] POS_LIMIT = (OUT_WIDTH'(1) << (OUT_WIDTH - 1)) - OUT_WIDTH'(1);
    localparam logic [OUT_WIDTH-1:0] NEG_MAG   = OUT_WIDTH'(1) << (OUT_WIDTH - 1);

    // divide by three, a byte per stage
    localparam int DIV_BITS     = 8;
    localparam int DIV_IN_WIDTH = OUT_WIDTH + 1;
    localparam int DIV_STAGES   = (DIV_IN_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_WIDTH    = DIV_STAGES * DIV_BITS;

    // stream buses
    localparam int TDATA_IN_WIDTH  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int TDATA_OUT_WIDTH = ((2 * OUT_WIDTH + 7) / 8) * 8;
    localparam int TUSER_WIDTH     = 2;
    localparam int TUSER_TOO_FEW   = 0;
    localparam int TUSER_OVF       = 1;

    // result queue
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PEND_WIDTH = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic                 valid;
        logic                 too_few;
        logic [ACC_WIDTH-1:0] simp;
        logic [ACC_WIDTH-1:0] tail;
    } t_lane_in;

    typedef struct packed {
        logic                 valid;
        logic                 too_few;
        logic                 sat;
        logic [OUT_WIDTH-1:0] value;
    } t_lane_out;

    typedef struct packed {
        logic                 too_few;
        logic                 ovf;
        logic [OUT_WIDTH-1:0] im;
        logic [OUT_WIDTH-1:0] re;
    } t_result;

endpackage

@@ hw/rtl/ssi_accum.sv @@
// ----------------------------------------------------------------------------
// ssi_accum: per-sample weighting and accumulation
// picks simpson and 3/8 weights from the sample index and closes a run
// ----------------------------------------------------------------------------
module ssi_accum
    import ssi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_re,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_im,
    input  logic [NP_WIDTH-1:0]     i_num_points,
    output logic                    o_emit,
    output t_lane_in                o_lane_re,
    output t_lane_in                o_lane_im
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] r_count;
    logic [ACC_WIDTH-1:0]   r_simp_re, r_simp_im, r_tail_re, r_tail_im;
    logic [ACC_WIDTH-1:0]   n_simp_re, n_simp_im, n_tail_re, n_tail_im;
    logic [ACC_WIDTH-1:0]   re_x, im_x;
    logic [CMP_WIDTH-1:0]   n_ext, i_ext, last_idx, tail_start;
    logic                   too_few, last, in_run, edge_s;
    logic                   ws1, ws2, ws4, wt1, wt3;
    t_lane_in               r_lane_re, r_lane_im;

    assign n_ext      = CMP_WIDTH'(i_num_points);
    assign i_ext      = CMP_WIDTH'(r_count);
    assign last_idx   = n_ext - CMP_WIDTH'(1);
    assign tail_start = n_ext - CMP_WIDTH'(TAIL_POINTS);
    assign too_few    = n_ext < CMP_WIDTH'(MIN_POINTS);
    assign in_run     = i_ext < n_ext;
    assign last       = ((i_ext + CMP_WIDTH'(1)) >= n_ext) || (r_count == COUNT_MAX);

    assign re_x = {{(ACC_WIDTH-SAMPLE_WIDTH){i_sample_re[SAMPLE_WIDTH-1]}}, i_sample_re};
    assign im_x = {{(ACC_WIDTH-SAMPLE_WIDTH){i_sample_im[SAMPLE_WIDTH-1]}}, i_sample_im};

    // weight selects: simpson 1/2/4, tail 1/3
    always_comb begin
        ws1    = 1'b0;
        ws2    = 1'b0;
        ws4    = 1'b0;
        wt1    = 1'b0;
        wt3    = 1'b0;
        edge_s = 1'b0;
        if (in_run) begin
            if (i_num_points[0]) begin
                edge_s = (i_ext == '0) || (i_ext == last_idx);
                ws1    = edge_s;
                ws4    = !edge_s && r_count[0];
                ws2    = !edge_s && !r_count[0];
            end else begin
                if ((n_ext > CMP_WIDTH'(TAIL_POINTS)) && (i_ext <= tail_start)) begin
                    edge_s = (i_ext == '0) || (i_ext == tail_start);
                    ws1    = edge_s;
                    ws4    = !edge_s && r_count[0];
                    ws2    = !edge_s && !r_count[0];
                end
                if (i_ext >= tail_start) begin
                    wt1 = (i_ext == tail_start) || (i_ext == last_idx);
                    wt3 = !wt1;
                end
            end
        end
    end

    always_comb begin
        n_simp_re = r_simp_re + (ws1 ? re_x : '0) + (ws2 ? (re_x << 1) : '0)
                  + (ws4 ? (re_x << 2) : '0);
        n_simp_im = r_simp_im + (ws1 ? im_x : '0) + (ws2 ? (im_x << 1) : '0)
                  + (ws4 ? (im_x << 2) : '0);
        n_tail_re = r_tail_re + ((wt1 || wt3) ? re_x : '0) + (wt3 ? (re_x << 1) : '0);
        n_tail_im = r_tail_im + ((wt1 || wt3) ? im_x : '0) + (wt3 ? (im_x << 1) : '0);
    end

    assign o_emit = i_accept && (too_few || last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_simp_re <= '0;
            r_simp_im <= '0;
            r_tail_re <= '0;
            r_tail_im <= '0;
        end else if (i_accept) begin
            if (too_few || last) begin
                r_count   <= '0;
                r_simp_re <= '0;
                r_simp_im <= '0;
                r_tail_re <= '0;
                r_tail_im <= '0;
            end else begin
                r_count   <= r_count + COUNT_WIDTH'(1);
                r_simp_re <= n_simp_re;
                r_simp_im <= n_simp_im;
                r_tail_re <= n_tail_re;
                r_tail_im <= n_tail_im;
            end
        end
    end

    // hand the closed run to the finishing lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_re.valid <= 1'b0;
            r_lane_im.valid <= 1'b0;
        end else begin
            r_lane_re.valid <= o_emit;
            r_lane_im.valid <= o_emit;
        end
        r_lane_re.too_few <= too_few;
        r_lane_im.too_few <= too_few;
        r_lane_re.simp    <= too_few ? '0 : n_simp_re;
        r_lane_re.tail    <= too_few ? '0 : n_tail_re;
        r_lane_im.simp    <= too_few ? '0 : n_simp_im;
        r_lane_im.tail    <= too_few ? '0 : n_tail_im;
    end

    assign o_lane_re = r_lane_re;
    assign o_lane_im = r_lane_im;

endmodule

@@ hw/rtl/ssi_lane.sv @@
// ----------------------------------------------------------------------------
// ssi_lane: final scaling of one component
// h*(8s+9t) / (3*2^19), round half away from zero, saturate to 48 bits
// ----------------------------------------------------------------------------
module ssi_lane
    import ssi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [STEP_WIDTH-1:0] i_step_size,
    input  t_lane_in              i_lane,
    output t_lane_out             o_lane
);

    // stage map: x, magnitude, low product, high product, scale, divide..., output
    localparam int ST_DIV = 5;
    localparam int ST_OUT = ST_DIV + DIV_STAGES;
    localparam int NSTAGE = ST_OUT + 1;

    function automatic logic [DIV_BITS+1:0] div3_byte(input logic [1:0]          rem_in,
                                                      input logic [DIV_BITS-1:0] d);
        logic [2:0]          r;
        logic [DIV_BITS-1:0] q;
        r = {1'b0, rem_in};
        q = '0;
        for (int j = DIV_BITS - 1; j >= 0; j--) begin
            r = {r[1:0], d[j]};
            if (r >= 3'd3) begin
                q[j] = 1'b1;
                r    = r - 3'd3;
            end
        end
        return {r[1:0], q};
    endfunction

    logic                    r_vld [NSTAGE];
    logic                    r_few [NSTAGE];
    logic                    r_neg [1:NSTAGE-2];
    logic                    r_sat [4:NSTAGE-1];
    logic [X_WIDTH-1:0]      r_x;
    logic [MAG_WIDTH-1:0]    r_mag;
    logic [PLO_WIDTH-1:0]    r_plo, r_plo2;
    logic [MAG_HI_WIDTH-1:0] r_mhi;
    logic [PHI_WIDTH-1:0]    r_phi;
    logic [V_WIDTH-1:0]      r_v;
    logic [DIV_WIDTH-1:0]    r_dw  [DIV_STAGES];
    logic [1:0]              r_rem [DIV_STAGES];
    logic [OUT_WIDTH-1:0]    r_value;

    logic [X_WIDTH-1:0]      simp_x, tail_x, n_x;
    logic [PROD_WIDTH-1:0]   prod;
    logic [V_WIDTH-1:0]      n_v;
    logic                    n_sat;
    logic [DIV_WIDTH-1:0]    n_dw  [DIV_STAGES];
    logic [1:0]              n_rem [DIV_STAGES];
    logic [DIV_BITS+1:0]     step;
    logic [OUT_WIDTH-1:0]    mag_out;

    assign simp_x = {{(X_WIDTH-ACC_WIDTH){i_lane.simp[ACC_WIDTH-1]}}, i_lane.simp};
    assign tail_x = {{(X_WIDTH-ACC_WIDTH){i_lane.tail[ACC_WIDTH-1]}}, i_lane.tail};
    assign n_x    = (simp_x << 3) + (tail_x << 3) + tail_x;

    assign prod  = PROD_WIDTH'(r_plo2) + (PROD_WIDTH'(r_phi) << MAG_LO_WIDTH) + ROUND_ADD;
    assign n_v   = prod[PROD_WIDTH-1:SCALE_SHIFT];
    assign n_sat = r_neg[3] ? (n_v >= SAT_NEG) : (n_v >= SAT_POS);

    // long division by three, msb first, quotient bits replace dividend bits
    always_comb begin
        n_dw[0]  = DIV_WIDTH'(r_v[DIV_IN_WIDTH-1:0]);
        step     = div3_byte(2'd0, n_dw[0][DIV_WIDTH-1 -: DIV_BITS]);
        n_dw[0][DIV_WIDTH-1 -: DIV_BITS] = step[DIV_BITS-1:0];
        n_rem[0] = step[DIV_BITS+1:DIV_BITS];
        for (int d = 1; d < DIV_STAGES; d++) begin
            step     = div3_byte(r_rem[d-1], r_dw[d-1][DIV_WIDTH-1-d*DIV_BITS -: DIV_BITS]);
            n_dw[d]  = r_dw[d-1];
            n_dw[d][DIV_WIDTH-1-d*DIV_BITS -: DIV_BITS] = step[DIV_BITS-1:0];
            n_rem[d] = step[DIV_BITS+1:DIV_BITS];
        end
    end

    assign mag_out = r_sat[ST_OUT-1] ? (r_neg[ST_OUT-1] ? NEG_MAG : POS_LIMIT)
                                     : r_dw[DIV_STAGES-1][OUT_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTAGE; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_lane.valid;
            for (int s = 1; s < NSTAGE; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_few[0] <= i_lane.too_few;
        for (int s = 1; s < NSTAGE; s++) begin
            r_few[s] <= r_few[s-1];
        end
        // x = 8s + 9t
        r_x      <= n_x;
        // sign and magnitude
        r_neg[1] <= r_x[X_WIDTH-1];
        r_mag    <= MAG_WIDTH'(r_x[X_WIDTH-1] ? (X_WIDTH'(0) - r_x) : r_x);
        for (int s = 2; s <= NSTAGE - 2; s++) begin
            r_neg[s] <= r_neg[s-1];
        end
        // partial products, one multiplier per stage
        r_plo    <= PLO_WIDTH'(r_mag[MAG_LO_WIDTH-1:0]) * PLO_WIDTH'(i_step_size);
        r_mhi    <= r_mag[MAG_WIDTH-1:MAG_LO_WIDTH];
        r_phi    <= PHI_WIDTH'(r_mhi) * PHI_WIDTH'(i_step_size);
        r_plo2   <= r_plo;
        // rounding, scaling and saturation test
        r_v      <= n_v;
        r_sat[4] <= n_sat;
        for (int s = 5; s <= NSTAGE - 1; s++) begin
            r_sat[s] <= r_sat[s-1];
        end
        for (int d = 0; d < DIV_STAGES; d++) begin
            r_dw[d]  <= n_dw[d];
            r_rem[d] <= n_rem[d];
        end
        r_value  <= r_neg[ST_OUT-1] ? (OUT_WIDTH'(0) - mag_out) : mag_out;
    end

    assign o_lane.valid   = r_vld[ST_OUT];
    assign o_lane.too_few = r_few[ST_OUT];
    assign o_lane.sat     = r_sat[ST_OUT] && r_vld[ST_OUT];
    assign o_lane.value   = r_value;

endmodule

@@ hw/rtl/ssi_out_fifo.sv @@
// ----------------------------------------------------------------------------
// ssi_out_fifo: result queue
// holds finished results until the downstream side takes them
// ----------------------------------------------------------------------------
module ssi_out_fifo
    import ssi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_en,
    input  t_result i_wr_data,
    input  logic    i_rd_en,
    output t_result o_rd_data,
    output logic    o_not_empty
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [PEND_WIDTH-1:0] r_count;
    t_result               r_out;
    logic                  r_out_vld;

    logic out_free, wr_direct, wr_mem, rd_mem;

    // output register, filled straight from the write side when the array is empty
    assign out_free  = !r_out_vld || i_rd_en;
    assign wr_direct = i_wr_en && out_free && (r_count == '0);
    assign wr_mem    = i_wr_en && !wr_direct;
    assign rd_mem    = out_free && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (wr_mem) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_mem) begin
            r_out <= r_mem[r_rd_ptr];
        end else if (wr_direct) begin
            r_out <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (wr_mem) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (rd_mem) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + PEND_WIDTH'(wr_mem) - PEND_WIDTH'(rd_mem);
            if (out_free) begin
                r_out_vld <= rd_mem || wr_direct;
            end
        end
    end

    assign o_rd_data   = r_out;
    assign o_not_empty = r_out_vld;

endmodule

@@ hw/rtl/simpson_stream_integrator.sv @@
// ----------------------------------------------------------------------------
// simpson_stream_integrator: streaming complex integrator, simpson + 3/8 tail
// one complex Q16.16 sample per transfer, one integral per run of num_points
// ----------------------------------------------------------------------------
// takes one sample per clock while ready; a run of num_points samples at grid
// spacing step_size closes on its last sample and yields one result transfer
// through the accumulator register and 13-stage finishing lanes (8s+9t, sign,
// two 28x32 partial products, round and scale, seven byte-wide divide-by-3
// stages, saturate); odd counts use simpson weights 1,4,2,...,4,1 times h/3,
// even counts simpson on the first n-3 samples and 1,3,3,1 on the last four
// times 3h/8; with num_points below 3 every sample returns a zero result with
// too_few_points set; results wait in a 32-entry queue, and s_axis_tready only
// drops once 32 results are outstanding (queued or in flight), so a stalled
// output never blocks input until then; write num_points and step_size only
// while the block is idle, writes take effect at the next clock
// ----------------------------------------------------------------------------
module simpson_stream_integrator
    import ssi_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration writes
    input  logic                       i_cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0]  i_cfg_addr,
    input  logic [CFG_WIDTH-1:0]       i_cfg_wdata,
    // sample stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [TDATA_IN_WIDTH-1:0]  s_axis_tdata,   // sample_re, sample_im
    // result stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [TDATA_OUT_WIDTH-1:0] m_axis_tdata,   // integral_re, integral_im
    output logic [TUSER_WIDTH-1:0]     m_axis_tuser    // too_few_points, overflowed
);

    logic [NP_WIDTH-1:0]   r_num_points;
    logic [STEP_WIDTH-1:0] r_step_size;
    logic [PEND_WIDTH-1:0] r_pending;

    logic      in_xfer, out_xfer, emit;
    t_lane_in  lane_in_re, lane_in_im;
    t_lane_out lane_out_re, lane_out_im;
    t_result   wr_data, rd_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= NUM_POINTS_RESET;
            r_step_size  <= STEP_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_NUM_POINTS: begin
                    r_num_points <= i_cfg_wdata[NP_WIDTH-1:0];
                end
                CFG_STEP_SIZE: begin
                    r_step_size <= i_cfg_wdata[STEP_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // results owed: counted from the accepting transfer to the output transfer,
    // so the queue always has room for everything in flight
    assign s_axis_tready = (r_pending < PEND_WIDTH'(FIFO_DEPTH));
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + PEND_WIDTH'(emit) - PEND_WIDTH'(out_xfer);
        end
    end

    ssi_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_xfer),
        .i_sample_re  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_sample_im  (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .i_num_points (r_num_points),
        .o_emit       (emit),
        .o_lane_re    (lane_in_re),
        .o_lane_im    (lane_in_im)
    );

    // real and imaginary parts finish in lockstep
    ssi_lane u_lane_re (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step_size (r_step_size),
        .i_lane      (lane_in_re),
        .o_lane      (lane_out_re)
    );

    ssi_lane u_lane_im (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step_size (r_step_size),
        .i_lane      (lane_in_im),
        .o_lane      (lane_out_im)
    );

    // overflowed flags either part saturating
    assign wr_data.too_few = lane_out_re.too_few;
    assign wr_data.ovf     = lane_out_re.sat || lane_out_im.sat;
    assign wr_data.re      = lane_out_re.value;
    assign wr_data.im      = lane_out_im.value;

    ssi_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (lane_out_re.valid && lane_out_im.valid),
        .i_wr_data   (wr_data),
        .i_rd_en     (out_xfer),
        .o_rd_data   (rd_data),
        .o_not_empty (m_axis_tvalid)
    );

    assign m_axis_tdata = TDATA_OUT_WIDTH'({rd_data.im, rd_data.re});

    always_comb begin
        m_axis_tuser                = '0;
        m_axis_tuser[TUSER_TOO_FEW] = rd_data.too_few;
        m_axis_tuser[TUSER_OVF]     = rd_data.ovf;
    end

endmodule

@@ hw/rtl/ssi_checker.sv @@
// ----------------------------------------------------------------------------
// ssi_checker: port-level checks of the simpson stream integrator
// watches the result stream and the reset behavior
// ----------------------------------------------------------------------------
module ssi_checker
    import ssi_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [TDATA_OUT_WIDTH-1:0] m_axis_tdata,
    input logic [TUSER_WIDTH-1:0]     m_axis_tuser
);

    logic [OUT_WIDTH-1:0] out_re, out_im;

    assign out_re = m_axis_tdata[OUT_WIDTH-1:0];
    assign out_im = m_axis_tdata[2*OUT_WIDTH-1:OUT_WIDTH];

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a short run gives a zero integral and no overflow
    a_too_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[TUSER_TOO_FEW] |->
            out_re == '0 && out_im == '0 && !m_axis_tuser[TUSER_OVF])
        else $error("too_few_points result not zero");

    // overflow means a part sits at a saturation limit
    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[TUSER_OVF] |->
            out_re == POS_LIMIT || out_re == NEG_MAG
            || out_im == POS_LIMIT || out_im == NEG_MAG)
        else $error("overflowed without a saturated part");

    // coming out of reset: input open, nothing to send
    a_reset_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> s_axis_tready && !m_axis_tvalid)
        else $error("bad state after reset");

endmodule

bind simpson_stream_integrator ssi_checker u_ssi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
